/* rtl/core/bctc_pkg.sv */
// Shared types and constants of the block cache tag controller.
`timescale 1ns / 1ps
package bctc_pkg;

    localparam int NUM_SLOTS = 32;
    localparam int ADDR_BITS = 32;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_FRD,
        S_MOD,
        S_VRD,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic                 bypass;
        logic                 hit;
        logic                 slot_valid;
        logic [SLOT_W-1:0]    slot;
        logic                 load_needed;
        logic                 writeback_needed;
        logic [ADDR_BITS-1:0] writeback_address;
        logic                 last;
    } t_result;

endpackage

/* rtl/core/bctc_engine.sv */
// Tag scan sequencer: tag memory, valid and dirty bits, victim pointer.
`timescale 1ns / 1ps
module bctc_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_vld,
    output logic                          o_in_rdy,
    input  bctc_pkg::t_cmd                i_cmd,
    input  logic [bctc_pkg::ADDR_BITS-1:0] i_addr,
    input  logic [bctc_pkg::CNT_W-1:0]    i_active,
    output logic                          o_res_vld,
    input  logic                          i_res_rdy,
    output bctc_pkg::t_result             o_res
);
    import bctc_pkg::*;

    localparam logic [CNT_W-1:0]  SLOT_CNT = CNT_W'(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    logic [ADDR_BITS-1:0] tag_mem [NUM_SLOTS];

    t_state               r_state, n_state;
    t_state               r_ret, n_ret;
    t_cmd                 r_cmd, n_cmd;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [SLOT_W-1:0]    r_idx, n_idx;
    logic                 r_free_vld, n_free_vld;
    logic [SLOT_W-1:0]    r_free_idx, n_free_idx;
    logic [SLOT_W-1:0]    r_vic, n_vic;
    logic [SLOT_W-1:0]    r_chosen, n_chosen;
    logic [NUM_SLOTS-1:0] r_valid, n_valid;
    logic [NUM_SLOTS-1:0] r_dirty, n_dirty;
    logic [ADDR_BITS-1:0] r_rd_data;
    t_result              r_res, n_res;

    logic [CNT_W-1:0]     act_n;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_wa;
    logic [NUM_SLOTS-1:0] above_mask;
    logic                 flush_last;
    logic                 step;
    logic                 is_write;
    logic [CNT_W-1:0]     chosen_inc;

    assign act_n      = (i_active > SLOT_CNT) ? SLOT_CNT : i_active;
    assign above_mask = ({NUM_SLOTS{1'b1}} << r_idx) << 1;
    assign flush_last = (r_valid & above_mask) == '0;
    assign is_write   = (r_cmd == CMD_WRITE);
    assign chosen_inc = {1'b0, r_chosen} + 1'b1;
    assign rd_addr    = (r_state == S_MOD) ? r_chosen : r_idx;

    assign o_in_rdy   = (r_state == S_IDLE);
    assign o_res_vld  = (r_state == S_WAIT);
    assign o_res      = r_res;

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_cmd      = r_cmd;
        n_addr     = r_addr;
        n_idx      = r_idx;
        n_free_vld = r_free_vld;
        n_free_idx = r_free_idx;
        n_vic      = r_vic;
        n_chosen   = r_chosen;
        n_valid    = r_valid;
        n_dirty    = r_dirty;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_wa     = r_idx;
        step       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_vld) begin
                    n_cmd      = i_cmd;
                    n_addr     = i_addr;
                    n_idx      = '0;
                    n_free_vld = 1'b0;
                    n_res      = '0;
                    n_res.last = 1'b1;
                    n_ret      = S_IDLE;
                    unique case (i_cmd)
                        CMD_READ, CMD_WRITE: begin
                            if (act_n == '0) begin
                                n_res.bypass = 1'b1;
                                n_state      = S_WAIT;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        CMD_FLUSH: n_state = S_SCAN;
                        default:   n_state = S_WAIT;
                    endcase
                end
            end
            S_SCAN: begin
                if (r_valid[r_idx]) begin
                    if (r_cmd == CMD_FLUSH) begin
                        if (r_dirty[r_idx]) begin
                            n_state = S_FRD;
                        end else begin
                            n_res            = '0;
                            n_res.slot_valid = 1'b1;
                            n_res.slot       = r_idx;
                            n_res.last       = flush_last;
                            n_valid[r_idx]   = 1'b0;
                            n_ret            = flush_last ? S_IDLE : S_SCAN;
                            n_idx            = r_idx + 1'b1;
                            n_state          = S_WAIT;
                        end
                    end else begin
                        n_state = S_CMP;
                    end
                end else begin
                    if (!r_free_vld && ({1'b0, r_idx} < act_n)) begin
                        n_free_vld = 1'b1;
                        n_free_idx = r_idx;
                    end
                    step = 1'b1;
                end
            end
            S_FRD: begin
                n_res                   = '0;
                n_res.slot_valid        = 1'b1;
                n_res.slot              = r_idx;
                n_res.writeback_needed  = 1'b1;
                n_res.writeback_address = r_rd_data;
                n_res.last              = flush_last;
                n_valid[r_idx]          = 1'b0;
                n_dirty[r_idx]          = 1'b0;
                n_ret                   = flush_last ? S_IDLE : S_SCAN;
                n_idx                   = r_idx + 1'b1;
                n_state                 = S_WAIT;
            end
            S_CMP: begin
                if (r_rd_data == r_addr) begin
                    if (is_write) begin
                        n_dirty[r_idx] = 1'b1;
                    end
                    n_res            = '0;
                    n_res.hit        = 1'b1;
                    n_res.slot_valid = 1'b1;
                    n_res.slot       = r_idx;
                    n_res.last       = 1'b1;
                    n_ret            = S_IDLE;
                    n_state          = S_WAIT;
                end else begin
                    n_state = S_SCAN;
                    step    = 1'b1;
                end
            end
            S_MOD: begin
                if ({1'b0, r_chosen} >= act_n) begin
                    n_chosen = r_chosen - act_n[SLOT_W-1:0];
                end else begin
                    n_state = S_VRD;
                end
            end
            S_VRD: begin
                mem_we                  = 1'b1;
                mem_wa                  = r_chosen;
                n_res                   = '0;
                n_res.slot_valid        = 1'b1;
                n_res.slot              = r_chosen;
                n_res.load_needed       = 1'b1;
                n_res.writeback_needed  = r_valid[r_chosen] & r_dirty[r_chosen];
                n_res.writeback_address = (r_valid[r_chosen] & r_dirty[r_chosen]) ?
                                          r_rd_data : '0;
                n_res.last              = 1'b1;
                n_valid[r_chosen]       = 1'b1;
                n_dirty[r_chosen]       = is_write;
                n_vic                   = (chosen_inc == act_n) ? '0 :
                                          chosen_inc[SLOT_W-1:0];
                n_ret                   = S_IDLE;
                n_state                 = S_WAIT;
            end
            S_WAIT: begin
                if (i_res_rdy) begin
                    n_state = r_ret;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (step) begin
            if (r_idx != LAST_IDX) begin
                n_idx   = r_idx + 1'b1;
                n_state = S_SCAN;
            end else if (r_cmd == CMD_FLUSH) begin
                n_res      = '0;
                n_res.last = 1'b1;
                n_ret      = S_IDLE;
                n_state    = S_WAIT;
            end else if (n_free_vld) begin
                mem_we              = 1'b1;
                mem_wa              = n_free_idx;
                n_valid[n_free_idx] = 1'b1;
                n_dirty[n_free_idx] = is_write;
                n_res               = '0;
                n_res.slot_valid    = 1'b1;
                n_res.slot          = n_free_idx;
                n_res.load_needed   = 1'b1;
                n_res.last          = 1'b1;
                n_ret               = S_IDLE;
                n_state             = S_WAIT;
            end else begin
                n_chosen = r_vic;
                n_state  = S_MOD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            tag_mem[mem_wa] <= r_addr;
        end
        r_rd_data <= tag_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_valid <= '0;
            r_dirty <= '0;
            r_vic   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_valid <= n_valid;
            r_dirty <= n_dirty;
            r_vic   <= n_vic;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_addr     <= n_addr;
        r_idx      <= n_idx;
        r_free_vld <= n_free_vld;
        r_free_idx <= n_free_idx;
        r_chosen   <= n_chosen;
        r_res      <= n_res;
    end

`ifndef SYNTHESIS
    a_hit_no_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && r_res.hit) |-> (!r_res.load_needed && !r_res.writeback_needed))
        else $error("hit result requests a transfer");

    a_bypass_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && r_res.bypass) |-> (!r_res.slot_valid && r_res.last))
        else $error("bypass result names a slot");

    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> (r_valid == '0 && r_dirty == '0))
        else $error("slot bits not cleared by reset");

    a_load_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_res_vld) && r_res.load_needed) |-> r_valid[r_res.slot])
        else $error("loaded slot not valid");

    a_flush_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_res_vld) && r_cmd == CMD_FLUSH && r_res.slot_valid)
            |-> !r_valid[r_res.slot])
        else $error("flushed slot still valid");
`endif

endmodule

/* rtl/core/block_cache_tag_controller.sv */
// Top level of the block cache tag controller: stream ports, config, output register.
//
// Channel  | Dir | Beat contents
// s_axis   | in  | tdata: command[1:0], address[33:2]
// m_axis   | out | tdata: bypass, hit, slot_valid, slot, load, writeback, wb address; tlast
// cfg      | in  | i_cfg_we with i_cfg_wdata: active slot count
//
// An access scans the tags one slot a cycle while no result is pending; a valid slot takes a
// tag memory read, then the shared compare. A miss with no free slot adds victim reduction,
// one tag read and one update. Flush emits one beat per valid slot, or one empty last beat if
// none is valid. Reset clears valid and dirty bits at once; no clearing pass. The block takes a
// new item only when idle and stalls its sequencer while the output register is full.
`timescale 1ns / 1ps
module block_cache_tag_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // command[1:0], address[33:2], zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // bypass, hit, slot_valid, slot[7:3], load_needed,
                                        // writeback_needed, writeback_address[41:10]
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata
);
    import bctc_pkg::*;

    logic [CNT_W-1:0] r_active;
    logic             r_m_vld;
    logic [47:0]      r_m_data;
    logic             r_m_last;
    logic             res_vld;
    logic             res_rdy;
    t_result          res;

    assign res_rdy = !r_m_vld || m_axis_tready;

    bctc_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_vld  (s_axis_tvalid),
        .o_in_rdy  (s_axis_tready),
        .i_cmd     (t_cmd'(s_axis_tdata[1:0])),
        .i_addr    (s_axis_tdata[33:2]),
        .i_active  (r_active),
        .o_res_vld (res_vld),
        .i_res_rdy (res_rdy),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_m_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (res_vld && res_rdy) begin
                r_m_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_rdy) begin
            r_m_data <= {6'd0, res.writeback_address, res.writeback_needed,
                         res.load_needed, res.slot, res.slot_valid, res.hit, res.bypass};
            r_m_last <= res.last;
        end
    end

    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;

endmodule

/* dv/tb_block_cache_tag_controller.sv */
// Testbench of the block cache tag controller: queued stream driver, beat checker, tag predictor.
`timescale 1ns / 1ps
module tb_block_cache_tag_controller;
    import bctc_pkg::*;

    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int POOL_SIZE      = 40;
    localparam int RAND_PHASES    = 7;

    typedef struct packed {
        t_cmd                 cmd;
        logic [ADDR_BITS-1:0] addr;
    } t_access;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // command[1:0], address[33:2], zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // bypass, hit, slot_valid, slot[7:3], load_needed,
                                       // writeback_needed, writeback_address[41:10]
    logic        m_axis_tlast;
    logic        i_cfg_we      = 1'b0;
    logic [5:0]  i_cfg_wdata   = '0;

    block_cache_tag_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // predictor state
    logic [ADDR_BITS-1:0] tag_mem [NUM_SLOTS];
    bit                   slot_vld [NUM_SLOTS];
    bit                   slot_dty [NUM_SLOTS];
    int                   next_victim = 0;
    logic [5:0]           slot_count  = '0;

    t_access pending_accesses[$];
    t_result expected_beats[$];
    t_access bus_access;

    int n_queued    = 0;
    int n_accepted  = 0;
    int n_beats     = 0;
    int n_errors    = 0;
    int n_hits      = 0;
    int n_wbacks    = 0;
    int n_bypass    = 0;
    int n_settings  = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    logic [ADDR_BITS-1:0] addr_pool [POOL_SIZE];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic predict_access(input t_access acc);
        int      n;
        int      chosen;
        int      n_valid;
        int      k;
        bit      found;
        t_result b;
        n = (slot_count > NUM_SLOTS) ? NUM_SLOTS : int'(slot_count);
        b = '0;
        if (acc.cmd == CMD_FLUSH) begin
            n_valid = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (slot_vld[i]) n_valid++;
            end
            if (n_valid == 0) begin
                b.last = 1'b1;
                expected_beats.push_back(b);
            end else begin
                k = 0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (slot_vld[i]) begin
                        k++;
                        b = '0;
                        b.slot_valid        = 1'b1;
                        b.slot              = SLOT_W'(i);
                        b.writeback_needed  = slot_dty[i];
                        b.writeback_address = slot_dty[i] ? tag_mem[i] : '0;
                        b.last              = (k == n_valid);
                        if (slot_dty[i]) n_wbacks++;
                        expected_beats.push_back(b);
                        slot_vld[i] = 1'b0;
                        slot_dty[i] = 1'b0;
                    end
                end
            end
        end else if (acc.cmd == CMD_RSVD) begin
            b.last = 1'b1;
            expected_beats.push_back(b);
        end else if (n == 0) begin
            b.bypass = 1'b1;
            b.last   = 1'b1;
            n_bypass++;
            expected_beats.push_back(b);
        end else begin
            found = 1'b0;
            for (int i = 0; i < NUM_SLOTS && !found; i++) begin
                if (slot_vld[i] && tag_mem[i] == acc.addr) begin
                    found = 1'b1;
                    if (acc.cmd == CMD_WRITE) slot_dty[i] = 1'b1;
                    b.hit        = 1'b1;
                    b.slot_valid = 1'b1;
                    b.slot       = SLOT_W'(i);
                    b.last       = 1'b1;
                end
            end
            if (found) begin
                n_hits++;
            end else begin
                chosen = n;
                for (int i = 0; i < n && chosen == n; i++) begin
                    if (!slot_vld[i]) chosen = i;
                end
                if (chosen == n) begin
                    chosen = next_victim % n;
                    if (slot_vld[chosen] && slot_dty[chosen]) begin
                        b.writeback_needed  = 1'b1;
                        b.writeback_address = tag_mem[chosen];
                        n_wbacks++;
                    end
                    next_victim = (chosen + 1) % n;
                end
                tag_mem[chosen]  = acc.addr;
                slot_vld[chosen] = 1'b1;
                slot_dty[chosen] = (acc.cmd == CMD_WRITE);
                b.slot_valid  = 1'b1;
                b.slot        = SLOT_W'(chosen);
                b.load_needed = 1'b1;
                b.last        = 1'b1;
            end
            expected_beats.push_back(b);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH beat %0d %s: got 0x%0h expected 0x%0h", n_beats, what, got, want);
        n_errors++;
    endtask

    task automatic check_beat();
        t_result want;
        if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat", m_axis_tdata[31:0], '0);
        end else begin
            want = expected_beats.pop_front();
            if (m_axis_tdata[0] !== want.bypass)
                report_mismatch("bypass", m_axis_tdata[0], want.bypass);
            if (m_axis_tdata[1] !== want.hit)
                report_mismatch("hit", m_axis_tdata[1], want.hit);
            if (m_axis_tdata[2] !== want.slot_valid)
                report_mismatch("slot_valid", m_axis_tdata[2], want.slot_valid);
            if (m_axis_tdata[7:3] !== want.slot)
                report_mismatch("slot", m_axis_tdata[7:3], want.slot);
            if (m_axis_tdata[8] !== want.load_needed)
                report_mismatch("load_needed", m_axis_tdata[8], want.load_needed);
            if (m_axis_tdata[9] !== want.writeback_needed)
                report_mismatch("writeback_needed", m_axis_tdata[9], want.writeback_needed);
            if (m_axis_tdata[41:10] !== want.writeback_address)
                report_mismatch("writeback_address", m_axis_tdata[41:10],
                                want.writeback_address);
            if (m_axis_tlast !== want.last)
                report_mismatch("last", m_axis_tlast, want.last);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_access(bus_access);
                n_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    bus_access = pending_accesses.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'b0, bus_access.addr, bus_access.cmd};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_beat();
                n_beats++;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_access(input t_cmd cmd, input logic [ADDR_BITS-1:0] addr);
        t_access a;
        a.cmd  = cmd;
        a.addr = addr;
        pending_accesses.push_back(a);
        n_queued++;
    endtask

    task automatic set_slot_count(input logic [5:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        slot_count  = value;
        n_settings++;
    endtask

    task automatic drain();
        while (n_accepted != n_queued || expected_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle(input int phase);
        if (phase < 5) begin
            send_idle_pct = 12;
            recv_idle_pct = 81;
        end else if (phase < 8) begin
            send_idle_pct = 81;
            recv_idle_pct = 12;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic add_random_access(input int span);
        int   r;
        t_cmd cmd;
        logic [ADDR_BITS-1:0] addr;
        r = $urandom_range(0, 99);
        if (r < 4)       cmd = CMD_FLUSH;
        else if (r < 6)  cmd = CMD_RSVD;
        else if (r < 50) cmd = CMD_READ;
        else             cmd = CMD_WRITE;
        if ($urandom_range(0, 1) == 0) addr = addr_pool[$urandom_range(0, span)];
        else                           addr = $urandom;
        add_access(cmd, addr);
    endtask

    initial begin
        logic [5:0] rand_cfg   [RAND_PHASES];
        int         rand_items [RAND_PHASES];
        int         span;
        rand_cfg   = '{6'd63, 6'd32, 6'd3, 6'd0, 6'd1, 6'd16, 6'd33};
        rand_items = '{30, 12, 10, 7, 8, 11, 11};
        for (int i = 0; i < NUM_SLOTS; i++) begin
            tag_mem[i]  = '0;
            slot_vld[i] = 1'b0;
            slot_dty[i] = 1'b0;
        end
        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // disabled cache: bypass, unused command, empty flush
        set_idle(0);
        set_slot_count(6'd0);
        add_access(CMD_READ, 32'h0000_0000);
        add_access(CMD_WRITE, 32'hFFFF_FFFF);
        add_access(CMD_RSVD, 32'h5A5A_5A5A);
        add_access(CMD_FLUSH, 32'h0000_0000);
        drain();

        // two slots: hit, dirty eviction, clean eviction, flush with writeback
        set_idle(1);
        set_slot_count(6'd2);
        add_access(CMD_WRITE, 32'h0000_0100);
        add_access(CMD_READ, 32'h0000_0200);
        add_access(CMD_READ, 32'h0000_0100);
        add_access(CMD_WRITE, 32'h0000_0300);
        add_access(CMD_READ, 32'h0000_0400);
        add_access(CMD_WRITE, 32'h0000_0300);
        add_access(CMD_FLUSH, 32'hFFFF_FFFF);
        drain();

        // fill five slots and advance the victim past two
        set_idle(2);
        set_slot_count(6'd5);
        for (int i = 0; i < 5; i++) add_access(CMD_WRITE, 32'h10 + i);
        for (int i = 0; i < 3; i++) add_access(CMD_READ, 32'h20 + i);
        drain();

        // shrink: hit above the active count, victim reduced modulo the count
        set_idle(3);
        set_slot_count(6'd2);
        add_access(CMD_READ, 32'h14);
        add_access(CMD_WRITE, 32'h30);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            set_idle(p + 4);
            set_slot_count(rand_cfg[p]);
            span = (rand_cfg[p] > NUM_SLOTS) ? NUM_SLOTS : int'(rand_cfg[p]);
            span = (span + 4 < POOL_SIZE) ? span + 4 : POOL_SIZE - 1;
            for (int j = 0; j < rand_items[p]; j++) add_random_access(span);
            drain();
        end

        $display("Covered %0d accesses and %0d result beats over %0d slot-count settings",
                 n_accepted, n_beats, n_settings);
        $display("Predicted %0d hits, %0d writebacks, %0d bypassed accesses; %0d mismatches",
                 n_hits, n_wbacks, n_bypass, n_errors);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
